FILE: hw/rtl/afrs_pkg.sv
// Shared types, constants and the slot search function of the frame reference selector.
package afrs_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int NUM_REFS  = 7;
  localparam int SLOT_W    = 3;
  localparam int HINT_W    = 8;
  localparam int BITS_W    = 4;
  localparam int NUM_BWD   = 3;
  localparam int NUM_FILL  = NUM_REFS - 2;
  // input reg + backward stages + forward fill stages + output reg
  localparam int PIPE_LAT  = 1 + NUM_BWD + NUM_FILL + 1;

  localparam logic [BITS_W-1:0] MAX_HINT_BITS = BITS_W'(HINT_W);

  localparam int REF_LAST    = 0;
  localparam int REF_LAST2   = 1;
  localparam int REF_LAST3   = 2;
  localparam int REF_GOLDEN  = 3;
  localparam int REF_BWDREF  = 4;
  localparam int REF_ALTREF2 = 5;
  localparam int REF_ALTREF  = 6;

  localparam int CFG_HINT_BITS   = 0;
  localparam int CFG_HINT_ENABLE = 1;

  // backward searches: ALTREF latest, then BWDREF and ALTREF2 earliest
  localparam int BWD_REF [NUM_BWD] = '{REF_ALTREF, REF_BWDREF, REF_ALTREF2};
  localparam bit BWD_EARLIEST [NUM_BWD] = '{1'b0, 1'b1, 1'b1};

  localparam int FILL_ORDER [NUM_FILL] =
    '{REF_LAST2, REF_LAST3, REF_BWDREF, REF_ALTREF2, REF_ALTREF};

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_LAST_LATE   = 2'd1,
    STATUS_GOLDEN_LATE = 2'd2
  } status_t;

  typedef logic [NUM_SLOTS-1:0][HINT_W-1:0] sh_t;

  typedef struct packed {
    logic                             valid;
    sh_t                              sh;
    logic [NUM_SLOTS-1:0]             bwd;
    logic [NUM_SLOTS-1:0]             used;
    logic [NUM_REFS-1:0][SLOT_W-1:0]  refs;
    logic [NUM_REFS-1:0]              set;
    logic [SLOT_W-1:0]                early;
    status_t                          status;
  } item_t;

  typedef struct packed {
    logic                             valid;
    logic [NUM_REFS-1:0][SLOT_W-1:0]  refs;
    status_t                          status;
  } result_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } pick_t;

  // Latest: ties go to the higher slot. Earliest: ties go to the lower slot.
  function automatic pick_t pick(sh_t sh, logic [NUM_SLOTS-1:0] cand, logic earliest);
    pick_t             r;
    logic [HINT_W-1:0] bh;
    r  = '0;
    bh = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (cand[i] && (!r.found || (earliest ? (sh[i] < bh) : (sh[i] >= bh)))) begin
        r.found = 1'b1;
        r.idx   = SLOT_W'(i);
        bh      = sh[i];
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/afrs_prep.sv
// Input stage: shifted slot hints, backward flags, LAST/GOLDEN setup and status.
module afrs_prep import afrs_pkg::*; (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [BITS_W-1:0]               hint_bits,
  input  logic                            hint_enable,
  input  logic                            accept,
  input  logic [SLOT_W-1:0]               last_ref_slot,
  input  logic [SLOT_W-1:0]               golden_ref_slot,
  input  logic [HINT_W-1:0]               current_order_hint,
  input  logic [NUM_SLOTS-1:0][HINT_W-1:0] slot_hint,
  output item_t                           item
);

  logic [BITS_W-1:0] bits_eff;
  logic [HINT_W-1:0] centre;
  item_t             item_next;

  always_comb begin
    if (hint_bits == '0) begin
      bits_eff = BITS_W'(1);
    end else if (hint_bits > MAX_HINT_BITS) begin
      bits_eff = MAX_HINT_BITS;
    end else begin
      bits_eff = hint_bits;
    end
    centre = HINT_W'(1) << (bits_eff - BITS_W'(1));
  end

  always_comb begin
    logic [HINT_W-1:0] d;
    d = '0;
    item_next       = '0;
    item_next.valid = accept;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      d = slot_hint[i] - current_order_hint;
      if (hint_enable) begin
        // centre + wrapped distance: low bits kept, sign bit flipped
        item_next.sh[i]  = (d & (centre - HINT_W'(1))) | (~d & centre);
        item_next.bwd[i] = (d & centre) == '0;
      end else begin
        item_next.sh[i]  = centre;
        item_next.bwd[i] = 1'b1;
      end
    end
    item_next.refs[REF_LAST]   = last_ref_slot;
    item_next.refs[REF_GOLDEN] = golden_ref_slot;
    item_next.set[REF_LAST]    = 1'b1;
    item_next.set[REF_GOLDEN]  = 1'b1;
    item_next.used[last_ref_slot]   = 1'b1;
    item_next.used[golden_ref_slot] = 1'b1;
    if (item_next.bwd[last_ref_slot]) begin
      item_next.status = STATUS_LAST_LATE;
    end else if (item_next.bwd[golden_ref_slot]) begin
      item_next.status = STATUS_GOLDEN_LATE;
    end else begin
      item_next.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      item <= item_next;
    end
  end

endmodule

FILE: hw/rtl/afrs_bwd.sv
// Backward search stages: ALTREF, BWDREF, ALTREF2, one per stage; earliest slot overall.
module afrs_bwd import afrs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  item_t item_in,
  output item_t item_out
);

  item_t stg  [NUM_BWD+1];
  item_t nxt  [NUM_BWD];

  assign stg[0]   = item_in;
  assign item_out = stg[NUM_BWD];

  for (genvar g = 0; g < NUM_BWD; g++) begin : g_stage
    pick_t p;
    pick_t p_all;

    assign p     = pick(stg[g].sh, ~stg[g].used & stg[g].bwd, BWD_EARLIEST[g]);
    assign p_all = pick(stg[g].sh, '1, 1'b1);

    always_comb begin
      nxt[g] = stg[g];
      if (g == 0) begin
        nxt[g].early = p_all.idx;
      end
      if (p.found) begin
        nxt[g].refs[BWD_REF[g]] = p.idx;
        nxt[g].set[BWD_REF[g]]  = 1'b1;
        nxt[g].used[p.idx]      = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[g+1].valid <= 1'b0;
      end else begin
        stg[g+1] <= nxt[g];
      end
    end
  end

endmodule

FILE: hw/rtl/afrs_fwd.sv
// Forward fill stages for empty references, then fallback to the earliest slot.
module afrs_fwd import afrs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item_in,
  output result_t res
);

  item_t   stg [NUM_FILL+1];
  item_t   nxt [NUM_FILL];
  result_t res_next;

  assign stg[0] = item_in;

  for (genvar g = 0; g < NUM_FILL; g++) begin : g_stage
    pick_t p;

    assign p = pick(stg[g].sh, ~stg[g].used & ~stg[g].bwd, 1'b0);

    always_comb begin
      nxt[g] = stg[g];
      if (!stg[g].set[FILL_ORDER[g]] && p.found) begin
        nxt[g].refs[FILL_ORDER[g]] = p.idx;
        nxt[g].set[FILL_ORDER[g]]  = 1'b1;
        nxt[g].used[p.idx]         = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[g+1].valid <= 1'b0;
      end else begin
        stg[g+1] <= nxt[g];
      end
    end
  end

  always_comb begin
    res_next.valid  = stg[NUM_FILL].valid;
    res_next.status = stg[NUM_FILL].status;
    for (int r = 0; r < NUM_REFS; r++) begin
      res_next.refs[r] = stg[NUM_FILL].set[r] ? stg[NUM_FILL].refs[r] : stg[NUM_FILL].early;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res <= res_next;
    end
  end

endmodule

FILE: hw/rtl/av1_frame_ref_selector.sv
// AV1 reference slot selector: a new frame header may be started every cycle
// (busy is high only during reset), and its seven reference slots and status
// appear on the result ports with done, for one cycle, after the input stage,
// eight search stages and the output register; the receiver cannot stall. The
// eight searches over the slots run one per pipeline stage, between the input
// stage and the output register. Configuration writes take effect at once and
// are meant to happen while no transaction is in flight.
module av1_frame_ref_selector import afrs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [BITS_W-1:0]   cfg_wdata,
  input  logic                start,
  output logic                busy,
  input  logic [SLOT_W-1:0]   last_ref_slot,
  input  logic [SLOT_W-1:0]   golden_ref_slot,
  input  logic [HINT_W-1:0]   current_order_hint,
  input  logic [HINT_W-1:0]   slot_hint_0,
  input  logic [HINT_W-1:0]   slot_hint_1,
  input  logic [HINT_W-1:0]   slot_hint_2,
  input  logic [HINT_W-1:0]   slot_hint_3,
  input  logic [HINT_W-1:0]   slot_hint_4,
  input  logic [HINT_W-1:0]   slot_hint_5,
  input  logic [HINT_W-1:0]   slot_hint_6,
  input  logic [HINT_W-1:0]   slot_hint_7,
  output logic                done,
  output logic [SLOT_W-1:0]   ref_last,
  output logic [SLOT_W-1:0]   ref_last2,
  output logic [SLOT_W-1:0]   ref_last3,
  output logic [SLOT_W-1:0]   ref_golden,
  output logic [SLOT_W-1:0]   ref_bwdref,
  output logic [SLOT_W-1:0]   ref_altref2,
  output logic [SLOT_W-1:0]   ref_altref,
  output logic [1:0]          status
);

  logic [BITS_W-1:0]                order_hint_bits;
  logic                             order_hint_enable;
  logic                             accept;
  logic [NUM_SLOTS-1:0][HINT_W-1:0] slot_hint;
  item_t                            prep_item;
  item_t                            bwd_item;
  result_t                          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_hint_bits   <= MAX_HINT_BITS;
      order_hint_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        1'(CFG_HINT_BITS):   order_hint_bits   <= cfg_wdata;
        1'(CFG_HINT_ENABLE): order_hint_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign busy   = rst;
  assign accept = start && !busy;

  assign slot_hint[0] = slot_hint_0;
  assign slot_hint[1] = slot_hint_1;
  assign slot_hint[2] = slot_hint_2;
  assign slot_hint[3] = slot_hint_3;
  assign slot_hint[4] = slot_hint_4;
  assign slot_hint[5] = slot_hint_5;
  assign slot_hint[6] = slot_hint_6;
  assign slot_hint[7] = slot_hint_7;

  afrs_prep u_prep (
    .clk                (clk),
    .rst                (rst),
    .hint_bits          (order_hint_bits),
    .hint_enable        (order_hint_enable),
    .accept             (accept),
    .last_ref_slot      (last_ref_slot),
    .golden_ref_slot    (golden_ref_slot),
    .current_order_hint (current_order_hint),
    .slot_hint          (slot_hint),
    .item               (prep_item)
  );

  afrs_bwd u_bwd (
    .clk      (clk),
    .rst      (rst),
    .item_in  (prep_item),
    .item_out (bwd_item)
  );

  afrs_fwd u_fwd (
    .clk     (clk),
    .rst     (rst),
    .item_in (bwd_item),
    .res     (res)
  );

  assign done        = res.valid;
  assign ref_last    = res.refs[REF_LAST];
  assign ref_last2   = res.refs[REF_LAST2];
  assign ref_last3   = res.refs[REF_LAST3];
  assign ref_golden  = res.refs[REF_GOLDEN];
  assign ref_bwdref  = res.refs[REF_BWDREF];
  assign ref_altref2 = res.refs[REF_ALTREF2];
  assign ref_altref  = res.refs[REF_ALTREF];
  assign status      = res.status;

`ifndef SYNTHESIS
  // every accepted transaction comes out of the pipeline with done
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##PIPE_LAT done)
    else $error("accepted transaction produced no result");

  // no result without a matching accepted transaction
  a_done_from_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PIPE_LAT))
    else $error("result without matching transaction");

  // LAST and GOLDEN pass through the pipeline unchanged
  a_last_golden_kept: assert property (@(posedge clk) disable iff (rst)
    done |-> (ref_last == $past(last_ref_slot, PIPE_LAT)) &&
             (ref_golden == $past(golden_ref_slot, PIPE_LAT)))
    else $error("LAST or GOLDEN slot corrupted");
`endif

endmodule
